@@ hdl/assert_macros.svh @@
// Assertion macros used by the sequencer of the PID unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising edge of clk_i, off while rst_ni is low.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Implication: when cond holds, res holds in the following cycle.
`define ASSERT_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEXT(lbl, cond, res)
`endif
`endif

@@ hdl/fppid_pkg.sv @@
// Types, constants and codes shared by the fixed-point PID unit.
package fppid_pkg;

  localparam int unsigned QBitsDefault = 24;
  localparam int unsigned DataW        = 32;
  localparam int unsigned SepW         = 31;
  localparam int unsigned AddrW        = 5;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_GAIN_BC    = 3'd4,
    REG_LIMIT_A    = 3'd5,
    REG_LIMIT_B    = 3'd6,
    REG_SEPARATION = 3'd7
  } reg_idx_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_SUM,
    S_CLAMP,
    S_MUL_B,
    S_UPDATE
  } ctrl_state_e;

  // Datapath step codes.
  typedef enum logic [3:0] {
    ST_NONE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_CLAMP,
    ST_MUL_B,
    ST_UPDATE
  } dp_step_e;

  typedef struct packed {
    logic     capture;
    logic     clear;
    dp_step_e step;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] setpoint;
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic signed [DataW-1:0] gain_bc;
    logic signed [DataW-1:0] limit_a;
    logic signed [DataW-1:0] limit_b;
    logic        [SepW-1:0]  separation;
  } cfg_t;

endpackage

@@ hdl/fppid_ctrl.sv @@
// Sequencer of the PID unit: walks the datapath through one control step.
module fppid_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             func_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fppid_pkg::dp_cmd_t cmd_o
);
  import fppid_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i && !func_i) state_d = S_ERR;
      S_ERR:    state_d = S_MUL_P;
      S_MUL_P:  state_d = S_MUL_I;
      S_MUL_I:  state_d = S_MUL_D;
      S_MUL_D:  state_d = S_SUM;
      S_SUM:    state_d = S_CLAMP;
      S_CLAMP:  state_d = S_MUL_B;
      S_MUL_B:  state_d = S_UPDATE;
      S_UPDATE: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = accept;
    cmd_o.clear   = accept && func_i;
    unique case (state_q)
      S_ERR:    cmd_o.step = ST_ERR;
      S_MUL_P:  cmd_o.step = ST_MUL_P;
      S_MUL_I:  cmd_o.step = ST_MUL_I;
      S_MUL_D:  cmd_o.step = ST_MUL_D;
      S_SUM:    cmd_o.step = ST_SUM;
      S_CLAMP:  cmd_o.step = ST_CLAMP;
      S_MUL_B:  cmd_o.step = ST_MUL_B;
      S_UPDATE: cmd_o.step = out_free ? ST_UPDATE : ST_NONE;
      default:  cmd_o.step = ST_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (state_q == S_UPDATE && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`include "assert_macros.svh"
  `ASSERT_NEXT(clear_takes_one_cycle, accept && func_i, state_q == S_IDLE)
  `ASSERT_NEXT(step_starts, accept && !func_i, state_q == S_ERR)
  `ASSERT_NEXT(result_posted, state_q == S_UPDATE && out_free, out_valid_q)
  `ASSERT_NEXT(blocked_update_waits, state_q == S_UPDATE && !out_free,
               state_q == S_UPDATE && out_valid_q)
endmodule

@@ hdl/fppid_datapath.sv @@
// Datapath of the PID unit: one shared multiplier and the step registers.
module fppid_datapath #(
  parameter int unsigned QBits = fppid_pkg::QBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fppid_pkg::cfg_t                     cfg_i,
  input  fppid_pkg::dp_cmd_t                  cmd_i,
  input  logic signed [fppid_pkg::DataW-1:0]  measured_i,
  output logic signed [fppid_pkg::DataW-1:0]  drive_out_o
);
  import fppid_pkg::*;

  logic signed [DataW-1:0]   meas_q, err_q, pt_q, it_q, v_q, u_q, hi_q, lo_q, drive_q;
  logic signed [DataW-1:0]   integ_q, last_q;
  logic signed [2*DataW-1:0] prod_q, prod_sh;
  logic signed [DataW-1:0]   mul_a, mul_b, qm, it_sel, clamped;
  logic        [DataW-1:0]   err_mag;
  logic                      sep_q;

  // Product scaled back by the Q format, floor toward minus infinity, then truncated.
  assign prod_sh = prod_q >>> QBits;
  assign qm      = prod_sh[DataW-1:0];
  assign err_mag = err_q[DataW-1] ? (-err_q) : err_q;
  assign it_sel  = sep_q ? '0 : it_q;

  always_comb begin
    unique case (cmd_i.step)
      ST_MUL_P: begin mul_a = cfg_i.gain_p;  mul_b = err_q;          end
      ST_MUL_I: begin mul_a = cfg_i.gain_i;  mul_b = err_q;          end
      ST_MUL_D: begin mul_a = cfg_i.gain_d;  mul_b = err_q - last_q; end
      ST_MUL_B: begin mul_a = cfg_i.gain_bc; mul_b = u_q - v_q;      end
      default:  begin mul_a = '0;            mul_b = '0;             end
    endcase
  end

  always_comb begin
    if (v_q > hi_q)      clamped = hi_q;
    else if (v_q < lo_q) clamped = lo_q;
    else                 clamped = v_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) meas_q <= measured_i;
    if (cmd_i.step == ST_MUL_P || cmd_i.step == ST_MUL_I ||
        cmd_i.step == ST_MUL_D || cmd_i.step == ST_MUL_B) begin
      prod_q <= mul_a * mul_b;
    end
    unique case (cmd_i.step)
      ST_ERR: begin
        err_q <= cfg_i.setpoint - meas_q;
        if (cfg_i.limit_a < cfg_i.limit_b) begin
          hi_q <= cfg_i.limit_b;
          lo_q <= cfg_i.limit_a;
        end else begin
          hi_q <= cfg_i.limit_a;
          lo_q <= cfg_i.limit_b;
        end
      end
      ST_MUL_P: sep_q <= err_mag > {1'b0, cfg_i.separation};
      ST_MUL_I: pt_q  <= qm;
      ST_MUL_D: it_q  <= qm + integ_q;
      ST_SUM: begin
        v_q  <= pt_q + it_sel + qm;
        it_q <= it_sel;
      end
      ST_CLAMP:  u_q     <= clamped;
      ST_UPDATE: drive_q <= u_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (cmd_i.clear) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (cmd_i.step == ST_UPDATE) begin
      integ_q <= it_q + qm;
      last_q  <= err_q;
    end
  end

  assign drive_out_o = drive_q;
endmodule

@@ hdl/fixed_point_pid_antiwindup_unit.sv @@
// Top level of the fixed-point PID unit: register file, sequencer and datapath.
//
// This unit runs one step of a Q-format PID controller with integral separation
// and back-calculation anti-windup for every compute request on the input
// channel, and posts the clamped drive value on the output channel. A compute
// request runs through eight steps, four of which use the single shared 32 x 32
// multiplier one after another. The unit is back in its idle state when the
// result is posted, so it can take the next request while that result is still
// shown; it takes no new request before the current one leaves its update step.
// A clear request resets the integral and the previous error in its accept
// cycle and posts no result. The output holds one finished result, so the next
// request is taken while that result still waits; only the final update step
// waits if the output is still full. Configuration registers sit on an APB
// port at byte addresses 4*i, and must only be written while the unit is idle.
module fixed_point_pid_antiwindup_unit #(
  parameter int unsigned Q_BITS = fppid_pkg::QBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic signed [fppid_pkg::DataW-1:0] measured_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fppid_pkg::DataW-1:0] drive_out_o,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [fppid_pkg::AddrW-1:0] paddr,
  input  logic        [31:0]                 pwdata,
  output logic        [31:0]                 prdata,
  output logic                               pready
);
  import fppid_pkg::*;

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  reg_idx_e reg_idx;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_e'(paddr[AddrW-1:2]);

  // Register file; the separation level keeps only its low 31 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{separation: {SepW{1'b1}}, default: '0};
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_SETPOINT:   cfg_q.setpoint   <= pwdata;
        REG_GAIN_P:     cfg_q.gain_p     <= pwdata;
        REG_GAIN_I:     cfg_q.gain_i     <= pwdata;
        REG_GAIN_D:     cfg_q.gain_d     <= pwdata;
        REG_GAIN_BC:    cfg_q.gain_bc    <= pwdata;
        REG_LIMIT_A:    cfg_q.limit_a    <= pwdata;
        REG_LIMIT_B:    cfg_q.limit_b    <= pwdata;
        REG_SEPARATION: cfg_q.separation <= pwdata[SepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SETPOINT:   prdata = cfg_q.setpoint;
      REG_GAIN_P:     prdata = cfg_q.gain_p;
      REG_GAIN_I:     prdata = cfg_q.gain_i;
      REG_GAIN_D:     prdata = cfg_q.gain_d;
      REG_GAIN_BC:    prdata = cfg_q.gain_bc;
      REG_LIMIT_A:    prdata = cfg_q.limit_a;
      REG_LIMIT_B:    prdata = cfg_q.limit_b;
      REG_SEPARATION: prdata = {1'b0, cfg_q.separation};
      default:        prdata = '0;
    endcase
  end

  // The sequencer owns the handshakes and tells the datapath which step to run.
  fppid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fppid_datapath #(
    .QBits (Q_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .measured_i  (measured_i),
    .drive_out_o (drive_out_o)
  );
endmodule
